@@ hdl/sma_pkg.sv @@
// Shared types, op codes and error codes of the stack machine ALU.
package sma_pkg;

   // Entry and field widths
   localparam int DataWidth  = 64;
   localparam int OpWidth    = 4;
   localparam int CountWidth = 9;
   localparam int ErrWidth   = 2;
   localparam int DefaultStackDepth = 256;

   // Op codes
   localparam logic [OpWidth-1:0] OpConst = 4'd0;
   localparam logic [OpWidth-1:0] OpAdd   = 4'd1;
   localparam logic [OpWidth-1:0] OpSub   = 4'd2;
   localparam logic [OpWidth-1:0] OpMul   = 4'd3;
   localparam logic [OpWidth-1:0] OpMax   = 4'd4;
   localparam logic [OpWidth-1:0] OpMin   = 4'd5;
   localparam logic [OpWidth-1:0] OpDiv   = 4'd6;
   localparam logic [OpWidth-1:0] OpNeg   = 4'd7;
   localparam logic [OpWidth-1:0] OpDup   = 4'd8;
   localparam logic [OpWidth-1:0] OpSwap  = 4'd9;

   // Error codes
   localparam logic [ErrWidth-1:0] ErrOk      = 2'd0;
   localparam logic [ErrWidth-1:0] ErrUnder   = 2'd1;
   localparam logic [ErrWidth-1:0] ErrOver    = 2'd2;
   localparam logic [ErrWidth-1:0] ErrDivZero = 2'd3;

   // Command to one stack cell
   typedef struct packed {
      logic load;      // take the load data
      logic shift_dn;  // take the entry from the cell above (push)
      logic shift_up;  // take the entry from the cell below (pop)
   } sma_cell_cmd_type;

endpackage

@@ hdl/sma_cell.sv @@
// One stack entry: holds, loads, or takes a neighbour's entry.
module sma_cell
   import sma_pkg::*;
(
   input  logic                 clock,
   input  sma_cell_cmd_type     cmd,
   input  logic [DataWidth-1:0] load_data,
   input  logic [DataWidth-1:0] up_data,
   input  logic [DataWidth-1:0] dn_data,
   output logic [DataWidth-1:0] entry
);

   logic [DataWidth-1:0] entry_ff;
   logic [DataWidth-1:0] entry_in;

   // Select the next entry
   always_comb begin
      priority if (cmd.load) begin
         entry_in = load_data;
      end else if (cmd.shift_dn) begin
         entry_in = up_data;
      end else if (cmd.shift_up) begin
         entry_in = dn_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ hdl/sma_mul.sv @@
// Wrapping 64-bit multiplier built from one shared 32x32 multiplier.
module sma_mul
   import sma_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DataWidth-1:0] op_a,
   input  logic [DataWidth-1:0] op_b,
   output logic                 busy,
   output logic                 done,
   output logic [DataWidth-1:0] product
);

   localparam int HalfWidth = DataWidth / 2;

   logic [DataWidth-1:0] a_ff, b_ff;
   logic [DataWidth-1:0] acc_ff, acc_in;
   logic [DataWidth-1:0] prod_ff, prod_in;
   logic [1:0]           phase_ff, phase_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [HalfWidth-1:0] mul_x, mul_y;

   // Pick the partial product for this phase
   always_comb begin
      unique case (phase_ff)
         2'd0: begin
            mul_x = a_ff[HalfWidth-1:0];
            mul_y = b_ff[HalfWidth-1:0];
         end
         2'd1: begin
            mul_x = a_ff[HalfWidth-1:0];
            mul_y = b_ff[DataWidth-1:HalfWidth];
         end
         default: begin
            mul_x = a_ff[DataWidth-1:HalfWidth];
            mul_y = b_ff[HalfWidth-1:0];
         end
      endcase
      prod_in = DataWidth'(mul_x) * DataWidth'(mul_y);
   end

   // Advance the phase and fold the registered product into the sum
   always_comb begin
      acc_in   = acc_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = '0;
         phase_in = 2'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         unique case (phase_ff)
            2'd0:    acc_in = acc_ff;
            2'd1:    acc_in = acc_ff + prod_ff;
            default: acc_in = acc_ff + {prod_ff[HalfWidth-1:0], {HalfWidth{1'b0}}};
         endcase
         if (phase_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ hdl/sma_div.sv @@
// Truncating signed divider, one quotient bit per cycle.
module sma_div
   import sma_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DataWidth-1:0] num,
   input  logic [DataWidth-1:0] den,
   output logic                 busy,
   output logic                 done,
   output logic [DataWidth-1:0] quotient
);

   localparam int CntWidth = $clog2(DataWidth);
   localparam logic [CntWidth-1:0] LastStep = CntWidth'(DataWidth - 1);

   logic [DataWidth-1:0] rem_ff, dvd_ff, md_ff;
   logic                 neg_ff;
   logic [CntWidth-1:0]  cnt_ff;
   logic                 busy_ff, done_ff;
   logic [DataWidth:0]   trial;

   assign trial = {rem_ff, dvd_ff[DataWidth-1]} - {1'b0, md_ff};

   // Control: count the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: restoring division on magnitudes
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= num[DataWidth-1] ? -num : num;
         md_ff  <= den[DataWidth-1] ? -den : den;
         neg_ff <= num[DataWidth-1] ^ den[DataWidth-1];
      end else if (busy_ff) begin
         if (!trial[DataWidth]) begin
            rem_ff <= trial[DataWidth-1:0];
            dvd_ff <= {dvd_ff[DataWidth-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DataWidth-2:0], dvd_ff[DataWidth-1]};
            dvd_ff <= {dvd_ff[DataWidth-2:0], 1'b0};
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? -dvd_ff : dvd_ff;

endmodule

@@ hdl/stack_machine_alu.sv @@
// Top level of the stack machine ALU: decode, stack cell chain and result register.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_op, req_value
//   rsp     | out       | rsp_valid / rsp_ready | rsp_top_value, rsp_stack_count, rsp_error
//
// const, add, sub, max, min, neg, dup, swap, undefined ops and every error finish on accept:
// the stack cells and the result register update at the accepting edge.
// mul takes four passes of the shared 32x32 multiplier, div one quotient bit per cycle;
// both pass StBusy and StFinish before the result loads. One item is in work at a time.
// Reset empties the stack at once; the cells themselves are not cleared.
// A full result register that is not taken holds the next result back and blocks req.
module stack_machine_alu
   import sma_pkg::*;
#(
   parameter int STACK_DEPTH = DefaultStackDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OpWidth-1:0]    req_op,
   input  logic signed [DataWidth-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [DataWidth-1:0] rsp_top_value,
   output logic [CountWidth-1:0] rsp_stack_count,
   output logic [ErrWidth-1:0]   rsp_error
);

   localparam int PtrWidth = $clog2(STACK_DEPTH + 1);
   localparam logic [PtrWidth-1:0] FullCount = PtrWidth'(STACK_DEPTH);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StBusy   = 2'd1;
   localparam logic [1:0] StFinish = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [PtrWidth-1:0]   sp_ff, sp_in;
   logic [ErrWidth-1:0]   err_ff, err_in;
   logic [OpWidth-1:0]    op_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0]  rsp_top_ff, rsp_top_in;
   logic [PtrWidth-1:0]   rsp_count_ff, rsp_count_in;
   logic [ErrWidth-1:0]   rsp_err_ff, rsp_err_in;

   logic                  accept, out_free;
   logic [DataWidth-1:0]  top_in;
   logic                  push, pop, swap, load_top;
   logic                  start_mul, start_div;
   logic                  mul_busy, mul_done, div_busy, div_done;
   logic [DataWidth-1:0]  mul_res, div_res;
   logic [DataWidth-1:0]  top, next;

   logic [DataWidth-1:0]   entry [STACK_DEPTH];
   sma_cell_cmd_type       cmd   [STACK_DEPTH];

   assign top  = entry[0];
   assign next = entry[1];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == StIdle) && out_free;
   assign accept    = req_valid && req_ready;

   // Decode the item and work out the next stack state
   always_comb begin
      top_in    = top;
      sp_in     = sp_ff;
      err_in    = ErrOk;
      push      = 1'b0;
      pop       = 1'b0;
      swap      = 1'b0;
      load_top  = 1'b0;
      start_mul = 1'b0;
      start_div = 1'b0;
      if (state_ff == StBusy) begin
         if (mul_done || div_done) begin
            top_in   = mul_done ? mul_res : div_res;
            pop      = 1'b1;
            load_top = 1'b1;
            sp_in    = sp_ff - 1'b1;
         end
      end else if (accept) begin
         unique case (req_op)
            OpConst, OpDup: begin
               if (req_op == OpDup && sp_ff == '0) begin
                  err_in = ErrUnder;
               end else if (sp_ff >= FullCount) begin
                  err_in = ErrOver;
               end else begin
                  top_in   = (req_op == OpDup) ? top : req_value;
                  push     = 1'b1;
                  load_top = 1'b1;
                  sp_in    = sp_ff + 1'b1;
               end
            end
            OpNeg: begin
               if (sp_ff == '0) begin
                  err_in = ErrUnder;
               end else begin
                  top_in   = -top;
                  load_top = 1'b1;
               end
            end
            OpAdd, OpSub, OpMul, OpMax, OpMin, OpDiv, OpSwap: begin
               if (sp_ff < PtrWidth'(2)) begin
                  err_in = ErrUnder;
               end else begin
                  unique case (req_op)
                     OpAdd: top_in = next + top;
                     OpSub: top_in = top - next;
                     OpMax: top_in = ($signed(next) < $signed(top)) ? top : next;
                     OpMin: top_in = ($signed(top) < $signed(next)) ? top : next;
                     OpSwap: top_in = next;
                     default: top_in = top;
                  endcase
                  if (req_op == OpMul) begin
                     start_mul = 1'b1;
                  end else if (req_op == OpDiv) begin
                     if (next == '0) begin
                        err_in = ErrDivZero;
                     end else begin
                        start_div = 1'b1;
                     end
                  end else if (req_op == OpSwap) begin
                     swap     = 1'b1;
                     load_top = 1'b1;
                  end else begin
                     pop      = 1'b1;
                     load_top = 1'b1;
                     sp_in    = sp_ff - 1'b1;
                  end
               end
            end
            default: begin
               // undefined op codes leave everything as it is
               top_in = top;
            end
         endcase
      end
   end

   // Drive the cell chain
   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         cmd[i].load     = 1'b0;
         cmd[i].shift_dn = push;
         cmd[i].shift_up = pop;
      end
      cmd[0].load = load_top;
      cmd[1].load = swap;
   end

   generate
      for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
         logic [DataWidth-1:0] up_data, dn_data, load_data;
         if (i == 0) begin : g_first
            assign up_data   = '0;
            assign load_data = top_in;
         end else begin : g_rest
            assign up_data   = entry[i-1];
            assign load_data = top;
         end
         if (i == STACK_DEPTH - 1) begin : g_last
            assign dn_data = '0;
         end else begin : g_inner
            assign dn_data = entry[i+1];
         end
         sma_cell u_cell (
            .clock     (clock),
            .cmd       (cmd[i]),
            .load_data (load_data),
            .up_data   (up_data),
            .dn_data   (dn_data),
            .entry     (entry[i])
         );
      end
   endgenerate

   sma_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (start_mul),
      .op_a    (next),
      .op_b    (top),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_res)
   );

   sma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_div),
      .num      (top),
      .den      (next),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_res)
   );

   // Sequence the item and load the result register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_top_in   = rsp_top_ff;
      rsp_count_in = rsp_count_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               if (start_mul || start_div) begin
                  state_in = StBusy;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_top_in   = (sp_in != '0) ? top_in : '0;
                  rsp_count_in = sp_in;
                  rsp_err_in   = err_in;
               end
            end
         end
         StBusy: begin
            if (mul_done || div_done) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_top_in   = (sp_ff != '0) ? top : '0;
               rsp_count_in = sp_ff;
               rsp_err_in   = err_ff;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         err_ff <= err_in;
      end
      rsp_top_ff   <= rsp_top_in;
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_stack_count = CountWidth'(rsp_count_ff);
   assign rsp_error       = rsp_err_ff;

`ifndef NO_ASSERTIONS
   // The entry count never passes the stack depth
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= FullCount)
      else $error("stack pointer beyond depth");

   // Only the unit named by the op runs, and never both at once
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StBusy) |-> ((mul_busy || mul_done) != (div_busy || div_done))
         && ((op_ff == OpMul) == (mul_busy || mul_done)))
      else $error("arithmetic unit out of step with op");

   // Overflow is reported only on a full stack, underflow only below two entries
   a_err_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_err_ff != ErrOver) || (rsp_count_ff == FullCount))
         && ((rsp_err_ff != ErrUnder) || (rsp_count_ff < PtrWidth'(2))))
      else $error("error code does not match stack count");

   // An empty stack reports a zero top
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_count_ff == '0) |-> (rsp_top_ff == '0))
      else $error("nonzero top on empty stack");
`endif

endmodule
